// ===== rtl/core/texture_row_pool_allocator_core_defines.svh =====
// Assertion macros for the texture row pool allocator core.
`ifndef TEXTURE_ROW_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define TEXTURE_ROW_POOL_ALLOCATOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TRPA_ASSERT_IMPL(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define TRPA_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define TRPA_ASSERT_IMPL(label, clk, rst, a, b)
`define TRPA_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/core/trpa_pkg.sv =====
// Package: types, constants and helpers of the texture row pool allocator.
`timescale 1ns / 1ps
package trpa_pkg;

   localparam int SLOTS      = 8;
   localparam int ROW_HEIGHT = 16;
   localparam int LEVELS     = 4;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int ROWS_MAX   = 16;

   localparam int TEX_SIZE [4] = '{32, 64, 128, 256};

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_COLLECT = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_LEVEL = 2'd1,
      ST_BAD_COUNT = 2'd2,
      ST_POOL_FULL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_CHECK,
      FSM_LAST,
      FSM_SCAN,
      FSM_OPEN
   } fsm_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [2:0] size_level;
      logic [4:0] row_count;
      logic [2:0] slot_index;
      logic [3:0] start_row;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] granted_slot;
      logic [3:0] granted_start;
      logic       opened_slot;
   } rsp_type;

   typedef struct packed {
      logic        hit;
      logic [3:0]  start;
      logic [15:0] mask;
   } fit_type;

   function automatic logic [4:0] rows_of(input logic [1:0] level);
      int r;
      r = TEX_SIZE[level] / ROW_HEIGHT;
      if (r > ROWS_MAX) r = ROWS_MAX;
      return 5'(r);
   endfunction

   function automatic logic [15:0] run_mask(input logic [4:0] count);
      logic [16:0] m;
      m = (17'd1 << count) - 17'd1;
      return (count >= 5'd16) ? 16'hFFFF : m[15:0];
   endfunction

endpackage

// ===== rtl/core/trpa_fit_unit.sv =====
// Shared first-fit unit: lowest free run of rows within one slot bitmap.
`timescale 1ns / 1ps
module trpa_fit_unit
   import trpa_pkg::*;
(
   input  logic [15:0] bitmap,
   input  logic [4:0]  rows,
   input  logic [4:0]  count,
   output fit_type     fit
);

   logic [15:0] base_mask;
   logic        hit;
   logic [3:0]  start;

   assign base_mask = run_mask(count);

   always_comb begin
      hit   = 1'b0;
      start = 4'd0;
      for (int i = 15; i >= 0; i--) begin
         if (((6'(i) + {1'b0, count}) <= {1'b0, rows}) &&
             (((base_mask << i) & bitmap) == 16'h0)) begin
            hit   = 1'b1;
            start = 4'(i);
         end
      end
   end

   assign fit.hit   = hit;
   assign fit.start = start;
   assign fit.mask  = base_mask << start;

endmodule

// ===== rtl/core/texture_row_pool_allocator_core.sv =====
// Top level: texture row pool allocator with slot scan sequencer.
//
// Usage:
//   A transaction is accepted on req when start is high and busy is low.
//   busy rises the cycle after acceptance and stays high until the result
//   is ready. Each transaction gives exactly one result on rsp, marked by
//   rsp_strobe for one cycle; the receiver cannot stall and must take it.
//   Steps from acceptance to rsp_strobe:
//     free, collect, unused opcode, bad level or bad count: check state only
//     allocate: check, then the last-used slot if it matches, then the scan
//     over up to SLOTS slots, then the open state if no slot had room.
//   The shared first-fit unit tests one slot per cycle; the scan over
//   slots sets the allocate latency. A new transaction may be accepted in
//   the cycle that rsp_strobe is high.
//   Reset (synchronous, active high) clears all slots, the last-used mark
//   and the sequencer; no result is pending afterwards.
`timescale 1ns / 1ps
`include "texture_row_pool_allocator_core_defines.svh"
module texture_row_pool_allocator_core
   import trpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_strobe,
   output rsp_type rsp
);

   fsm_type            state_ff, state_in;
   req_type            req_ff, req_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [SLOTS-1:0]   slot_valid_ff, slot_valid_in;
   logic [1:0]         slot_level_ff [SLOTS];
   logic [1:0]         slot_level_in [SLOTS];
   logic [15:0]        slot_bitmap_ff [SLOTS];
   logic [15:0]        slot_bitmap_in [SLOTS];
   logic [SLOT_W-1:0]  last_slot_ff, last_slot_in;
   logic               last_valid_ff, last_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;

   logic [SLOT_W-1:0]  fit_addr;
   logic [4:0]         rows;
   fit_type            fit;
   logic               free_found;
   logic [SLOT_W-1:0]  free_slot;
   logic [15:0]        free_mask;
   logic [4:0]         free_count;

   assign busy       = (state_ff != FSM_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   assign rows = rows_of(req_ff.size_level[1:0]);
   assign fit_addr = (state_ff == FSM_LAST) ? last_slot_ff : idx_ff;

   trpa_fit_unit u_fit (
      .bitmap (slot_bitmap_ff[fit_addr]),
      .rows   (rows),
      .count  (req_ff.row_count),
      .fit    (fit)
   );

   assign free_count = (req_ff.row_count > 5'd16) ? 5'd16 : req_ff.row_count;
   assign free_mask  = run_mask(free_count) << req_ff.start_row;

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (!slot_valid_ff[s]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         idx_ff        <= '0;
         slot_valid_ff <= '0;
         last_slot_ff  <= '0;
         last_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
         for (int s = 0; s < SLOTS; s++) begin
            slot_level_ff[s]  <= 2'd0;
            slot_bitmap_ff[s] <= 16'h0;
         end
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         slot_valid_ff <= slot_valid_in;
         last_slot_ff  <= last_slot_in;
         last_valid_ff <= last_valid_in;
         strobe_ff     <= strobe_in;
         slot_level_ff  <= slot_level_in;
         slot_bitmap_ff <= slot_bitmap_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      idx_in         = idx_ff;
      slot_valid_in  = slot_valid_ff;
      slot_level_in  = slot_level_ff;
      slot_bitmap_in = slot_bitmap_ff;
      last_slot_in   = last_slot_ff;
      last_valid_in  = last_valid_ff;
      rsp_in         = rsp_ff;
      strobe_in      = 1'b0;

      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = FSM_CHECK;
            end
         end
         FSM_CHECK: begin
            rsp_in = '0;
            idx_in = '0;
            case (opcode_type'(req_ff.opcode))
               OP_ALLOC: begin
                  if (req_ff.size_level >= 3'(LEVELS)) begin
                     rsp_in.status = ST_BAD_LEVEL;
                     strobe_in     = 1'b1;
                     state_in      = FSM_IDLE;
                  end else if (req_ff.row_count > rows) begin
                     rsp_in.status = ST_BAD_COUNT;
                     strobe_in     = 1'b1;
                     state_in      = FSM_IDLE;
                  end else if (last_valid_ff && slot_valid_ff[last_slot_ff] &&
                               slot_level_ff[last_slot_ff] == req_ff.size_level[1:0]) begin
                     state_in = FSM_LAST;
                  end else begin
                     state_in = FSM_SCAN;
                  end
               end
               OP_FREE: begin
                  if (slot_valid_ff[req_ff.slot_index]) begin
                     slot_bitmap_in[req_ff.slot_index] =
                        slot_bitmap_ff[req_ff.slot_index] & ~free_mask;
                  end
                  strobe_in = 1'b1;
                  state_in  = FSM_IDLE;
               end
               OP_COLLECT: begin
                  for (int s = 0; s < SLOTS; s++) begin
                     if (slot_valid_ff[s] && slot_bitmap_ff[s] == 16'h0) begin
                        slot_valid_in[s] = 1'b0;
                        slot_level_in[s] = 2'd0;
                        if (last_valid_ff && last_slot_ff == SLOT_W'(s))
                           last_valid_in = 1'b0;
                     end
                  end
                  strobe_in = 1'b1;
                  state_in  = FSM_IDLE;
               end
               default: begin
                  strobe_in = 1'b1;
                  state_in  = FSM_IDLE;
               end
            endcase
         end
         FSM_LAST, FSM_SCAN: begin
            if (fit.hit && (state_ff == FSM_LAST ||
                (slot_valid_ff[idx_ff] &&
                 slot_level_ff[idx_ff] == req_ff.size_level[1:0]))) begin
               slot_bitmap_in[fit_addr] = slot_bitmap_ff[fit_addr] | fit.mask;
               last_slot_in          = fit_addr;
               last_valid_in         = 1'b1;
               rsp_in.granted_slot   = 3'(fit_addr);
               rsp_in.granted_start  = fit.start;
               strobe_in             = 1'b1;
               state_in              = FSM_IDLE;
            end else if (state_ff == FSM_LAST) begin
               state_in = FSM_SCAN;
            end else if (idx_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = FSM_OPEN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         FSM_OPEN: begin
            if (free_found) begin
               slot_valid_in[free_slot]  = 1'b1;
               slot_level_in[free_slot]  = req_ff.size_level[1:0];
               slot_bitmap_in[free_slot] = run_mask(req_ff.row_count);
               last_slot_in              = free_slot;
               last_valid_in             = 1'b1;
               rsp_in.granted_slot       = 3'(free_slot);
               rsp_in.opened_slot        = 1'b1;
            end else begin
               rsp_in.status = ST_POOL_FULL;
            end
            strobe_in = 1'b1;
            state_in  = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   `TRPA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `TRPA_ASSERT_IMPL(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy) && !busy)
   `TRPA_ASSERT_IMPL(a_error_no_grant, clock, reset, rsp_strobe && rsp.status != ST_OK,
                     rsp.granted_slot == 3'd0 && rsp.opened_slot == 1'b0)
   `TRPA_ASSERT_IMPL(a_last_slot_live, clock, reset, last_valid_ff,
                     slot_valid_ff[last_slot_ff])

endmodule

// ===== dv/tb_top.sv =====
// Testbench for texture_row_pool_allocator_core: directed and random allocate, free and collect traffic.
`timescale 1ns / 1ps
module tb_top;
   import trpa_pkg::*;

   localparam int RANDOM_ITEMS = 1800;
   localparam int STALL_LIMIT  = 4000;
   localparam int SETTLE       = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp;

   texture_row_pool_allocator_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   always #5 clock = ~clock;

   // shadow copy of the slot pool
   bit          pool_valid [SLOTS] = '{default: 1'b0};
   logic [1:0]  pool_level [SLOTS] = '{default: 2'd0};
   logic [15:0] row_map    [SLOTS] = '{default: 16'd0};
   int          last_used = 0;
   bit          last_ok   = 1'b0;

   req_type pending [$];
   rsp_type due_results [$];
   int      items_taken = 0;
   int      errors = 0;
   int      quiet_cycles = 0;

   function automatic int rows_for(input int lv);
      int r;
      r = (32 << lv) / ROW_HEIGHT;
      return (r > 16) ? 16 : r;
   endfunction

   function automatic logic [15:0] run_bits(input int cnt);
      return (cnt >= 16) ? 16'hFFFF : 16'((1 << cnt) - 1);
   endfunction

   // lowest free run in slot s; marks the rows on success
   function automatic bit claim_run(input int s, input int rows, input int cnt,
                                    output logic [3:0] at);
      logic [15:0] m;
      logic [15:0] want;
      int i;
      m = run_bits(cnt);
      at = '0;
      for (i = 0; i + cnt <= rows; i++) begin
         want = m << i;
         if ((want & row_map[s]) == 16'd0) begin
            row_map[s] = row_map[s] | want;
            last_used = s;
            last_ok = 1'b1;
            at = 4'(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic rsp_type pool_update(input req_type q);
      rsp_type r;
      int lv, cnt, rows, s;
      bit done;
      logic [3:0] at;
      logic [15:0] m;
      r = '0;
      done = 1'b0;
      lv = q.size_level;
      cnt = q.row_count;
      case (q.opcode)
         OP_ALLOC: begin
            if (lv >= LEVELS) begin
               r.status = ST_BAD_LEVEL;
            end else if (cnt > rows_for(lv)) begin
               r.status = ST_BAD_COUNT;
            end else begin
               rows = rows_for(lv);
               s = last_used;
               if (last_ok && pool_valid[s] && pool_level[s] == lv &&
                   claim_run(s, rows, cnt, at)) begin
                  r.granted_slot = 3'(s);
                  r.granted_start = at;
                  done = 1'b1;
               end
               for (s = 0; s < SLOTS && !done; s++) begin
                  if (pool_valid[s] && pool_level[s] == lv && claim_run(s, rows, cnt, at)) begin
                     r.granted_slot = 3'(s);
                     r.granted_start = at;
                     done = 1'b1;
                  end
               end
               for (s = 0; s < SLOTS && !done; s++) begin
                  if (!pool_valid[s]) begin
                     pool_valid[s] = 1'b1;
                     pool_level[s] = 2'(lv);
                     row_map[s] = 16'd0;
                     void'(claim_run(s, rows, cnt, at));
                     r.granted_slot = 3'(s);
                     r.granted_start = at;
                     r.opened_slot = 1'b1;
                     done = 1'b1;
                  end
               end
               if (!done) r.status = ST_POOL_FULL;
            end
         end
         OP_FREE: begin
            if (pool_valid[q.slot_index]) begin
               m = run_bits((cnt > 16) ? 16 : cnt);
               m = m << q.start_row;
               row_map[q.slot_index] = row_map[q.slot_index] & ~m;
            end
         end
         OP_COLLECT: begin
            for (s = 0; s < SLOTS; s++) begin
               if (pool_valid[s] && row_map[s] == 16'd0) begin
                  pool_valid[s] = 1'b0;
                  pool_level[s] = 2'd0;
                  if (last_ok && last_used == s) last_ok = 1'b0;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_type mk(input opcode_type op, input int lv, input int cnt,
                                  input int sidx, input int srow);
      req_type q;
      q.opcode = op;
      q.size_level = 3'(lv);
      q.row_count = 5'(cnt);
      q.slot_index = 3'(sidx);
      q.start_row = 4'(srow);
      return q;
   endfunction

   task automatic add_item(input req_type q);
      pending = {pending, q};
   endtask

   // mostly well-formed traffic steered by the current pool contents
   function automatic req_type draw_request();
      req_type q;
      logic [16:0] raw;
      int roll, lv, rows, s, tries, found;
      raw = 17'($urandom);
      q = raw;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         lv = $urandom_range(0, LEVELS - 1);
         rows = rows_for(lv);
         q.opcode = OP_ALLOC;
         q.size_level = 3'(lv);
         if ($urandom_range(0, 3) == 0) q.row_count = 5'($urandom_range(0, rows));
         else q.row_count = 5'($urandom_range(1, (rows > 2) ? rows / 2 : rows));
      end else if (roll < 82) begin
         found = -1;
         for (tries = 0; tries < 16 && found < 0; tries++) begin
            s = $urandom_range(0, SLOTS - 1);
            if (pool_valid[s] && row_map[s] != 16'd0) found = s;
         end
         if (found < 0) begin
            q.opcode = OP_COLLECT;
         end else begin
            q.opcode = OP_FREE;
            q.slot_index = 3'(found);
            q.start_row = 4'($urandom_range(0, 15));
            for (tries = 0; tries < 16 && !row_map[found][q.start_row]; tries++)
               q.start_row = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 4) == 0) q.row_count = 5'($urandom_range(0, 31));
            else q.row_count = 5'($urandom_range(1, 4));
         end
      end else if (roll < 90) begin
         q.opcode = OP_COLLECT;
      end
      return q;
   endfunction

   task automatic note_mismatch(input string what, input logic [15:0] got,
                                input logic [15:0] want);
      $display("tb_top: mismatch %s got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      bit take;
      int idle_pct;
      if (reset) begin
         start <= 1'b0;
      end else begin
         take = start && !busy;
         if (take) begin
            due_results = {due_results, pool_update(req)};
            void'(pending.pop_front());
            items_taken++;
         end
         case ((items_taken / 120) % 4)
            1: idle_pct = 80;
            3: idle_pct = 25;
            default: idle_pct = 0;
         endcase
         if (!(start && !take)) begin
            if (pending.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               req <= pending[0];
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (due_results.size() == 0) begin
            note_mismatch("unsolicited result", 16'(rsp), 16'd0);
         end else begin
            e = due_results.pop_front();
            if (rsp.status !== e.status)
               note_mismatch("status", 16'(rsp.status), 16'(e.status));
            if (rsp.granted_slot !== e.granted_slot)
               note_mismatch("granted_slot", 16'(rsp.granted_slot), 16'(e.granted_slot));
            if (rsp.granted_start !== e.granted_start)
               note_mismatch("granted_start", 16'(rsp.granted_start), 16'(e.granted_start));
            if (rsp.opened_slot !== e.opened_slot)
               note_mismatch("opened_slot", 16'(rsp.opened_slot), 16'(e.opened_slot));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      int drawn;
      drawn = 0;
      add_item(mk(OP_ALLOC, 0, 0, 7, 15));
      add_item(mk(OP_ALLOC, 0, 2, 0, 0));
      add_item(mk(OP_ALLOC, 0, 1, 7, 15));
      add_item(mk(OP_ALLOC, 4, 1, 0, 0));
      add_item(mk(OP_ALLOC, 7, 31, 7, 15));
      add_item(mk(OP_ALLOC, 1, 5, 0, 0));
      add_item(mk(OP_ALLOC, 3, 17, 0, 0));
      add_item(mk(OP_ALLOC, 3, 31, 7, 15));
      add_item(mk(OP_ALLOC, 3, 16, 0, 0));
      add_item(mk(OP_ALLOC, 2, 8, 0, 0));
      add_item(mk(OP_ALLOC, 1, 4, 0, 0));
      add_item(mk(OP_ALLOC, 1, 4, 0, 0));
      add_item(mk(OP_ALLOC, 1, 4, 0, 0));
      add_item(mk(OP_ALLOC, 1, 4, 0, 0));
      add_item(mk(OP_ALLOC, 1, 1, 0, 0));
      add_item(mk(OP_FREE, 7, 4, 2, 4));
      add_item(mk(OP_ALLOC, 3, 3, 0, 0));
      add_item(mk(OP_FREE, 0, 31, 0, 0));
      add_item(mk(OP_FREE, 0, 16, 1, 15));
      add_item(mk(OP_FREE, 3, 16, 2, 0));
      add_item(mk(OP_COLLECT, 7, 31, 7, 15));
      add_item(mk(OP_FREE, 0, 4, 0, 0));
      add_item(mk(OP_NONE, 7, 31, 7, 15));
      add_item(mk(OP_ALLOC, 0, 0, 0, 0));
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (drawn < RANDOM_ITEMS) begin
         @(posedge clock);
         #1;
         if (pending.size() == 0) begin
            add_item(draw_request());
            drawn++;
         end
      end
      while (pending.size() != 0 || due_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && due_results.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
